>>> rtl/bfa_pkg.sv
// shared constants, codes and control/status structs of the best-fit allocator
// no dependencies; used by bfa_ctrl, bfa_dp and best_fit_allocator_coalescing
package bfa_pkg;

	localparam int FREE_ENTRIES_DEF = 64;
	localparam int USED_ENTRIES_DEF = 256;

	localparam int PADDR_W = 4;
	localparam int PDATA_W = 64;
	localparam logic [PADDR_W-4:0] REG_POOL_SIZE = '0;

	localparam logic [32:0] POOL_RESET = 33'h0_8000_1000;
	localparam logic [32:0] POOL_MAX   = 33'h1_0000_0000;

	localparam logic FUNC_FREE = 1'b1;

	localparam logic [2:0] ST_OK         = 3'd0;
	localparam logic [2:0] ST_NO_FIT     = 3'd1;
	localparam logic [2:0] ST_UNKNOWN    = 3'd2;
	localparam logic [2:0] ST_TABLE_FULL = 3'd3;
	localparam logic [2:0] ST_ZERO_SIZE  = 3'd4;

	localparam logic [3:0] OP_NONE   = 4'd0;
	localparam logic [3:0] OP_INIT   = 4'd1;
	localparam logic [3:0] OP_FIT    = 4'd2;
	localparam logic [3:0] OP_SLOT   = 4'd3;
	localparam logic [3:0] OP_LOOKUP = 4'd4;
	localparam logic [3:0] OP_POS    = 4'd5;
	localparam logic [3:0] OP_COMMIT = 4'd6;
	localparam logic [3:0] OP_DROP   = 4'd7;
	localparam logic [3:0] OP_MERGE  = 4'd8;
	localparam logic [3:0] OP_SHUP   = 4'd9;
	localparam logic [3:0] OP_INSERT = 4'd10;
	localparam logic [3:0] OP_RESULT = 4'd11;

	typedef struct packed {
		logic       load;
		logic       start;
		logic [3:0] op;
		logic [2:0] code;
	} bfa_cmd_t;

	typedef struct packed {
		logic done;
		logic found;
		logic hit;
		logic is_free;
		logic req_zero;
		logic empty;
		logic left;
		logic right;
		logic full;
	} bfa_stat_t;

endpackage

>>> rtl/bfa_ctrl.sv
// sequencing state machine of the best-fit allocator
// depends on bfa_pkg; drives bfa_dp through bfa_cmd_t, reads bfa_stat_t
module bfa_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output bfa_pkg::bfa_cmd_t cmd,
	input  bfa_pkg::bfa_stat_t stat
);
	import bfa_pkg::*;

	localparam logic [4:0] S_IDLE      = 5'd0;
	localparam logic [4:0] S_INIT      = 5'd1;
	localparam logic [4:0] S_DISP      = 5'd2;
	localparam logic [4:0] S_FIT       = 5'd3;
	localparam logic [4:0] S_FIT_CHK   = 5'd4;
	localparam logic [4:0] S_SLOT      = 5'd5;
	localparam logic [4:0] S_SLOT_CHK  = 5'd6;
	localparam logic [4:0] S_COMMIT    = 5'd7;
	localparam logic [4:0] S_DROP      = 5'd8;
	localparam logic [4:0] S_LOOKUP    = 5'd9;
	localparam logic [4:0] S_LOOK_CHK  = 5'd10;
	localparam logic [4:0] S_POS       = 5'd11;
	localparam logic [4:0] S_POS_CHK   = 5'd12;
	localparam logic [4:0] S_MERGE     = 5'd13;
	localparam logic [4:0] S_SHUP      = 5'd14;
	localparam logic [4:0] S_INSERT    = 5'd15;
	localparam logic [4:0] S_FIN       = 5'd16;

	logic [4:0] state_q, state_d;
	logic [2:0] code_q, code_d;
	logic       init_q, start_q, out_valid_q;
	logic [3:0] op;
	logic       res_load;

	assign in_ready  = (state_q == S_IDLE) && !init_q;
	assign out_valid = out_valid_q;
	assign res_load  = (state_q == S_FIN) && (!out_valid_q || out_ready);

	always_comb begin
		state_d = state_q;
		code_d  = code_q;
		op      = OP_NONE;
		unique case (state_q)
			S_IDLE: begin
				if (init_q)
					state_d = S_INIT;
				else if (in_valid)
					state_d = S_DISP;
			end
			S_INIT: begin
				op      = OP_INIT;
				state_d = S_IDLE;
			end
			S_DISP: begin
				if (stat.is_free) begin
					state_d = S_LOOKUP;
				end else if (stat.req_zero) begin
					code_d  = ST_ZERO_SIZE;
					state_d = S_FIN;
				end else begin
					state_d = S_FIT;
				end
			end
			S_FIT: begin
				op = OP_FIT;
				if (stat.done)
					state_d = S_FIT_CHK;
			end
			S_FIT_CHK: begin
				if (stat.found) begin
					state_d = S_SLOT;
				end else begin
					code_d  = ST_NO_FIT;
					state_d = S_FIN;
				end
			end
			S_SLOT: begin
				op = OP_SLOT;
				if (stat.done)
					state_d = S_SLOT_CHK;
			end
			S_SLOT_CHK: begin
				if (stat.hit) begin
					state_d = S_COMMIT;
				end else begin
					code_d  = ST_TABLE_FULL;
					state_d = S_FIN;
				end
			end
			S_COMMIT: begin
				op      = OP_COMMIT;
				code_d  = ST_OK;
				state_d = stat.empty ? S_DROP : S_FIN;
			end
			S_DROP: begin
				op = OP_DROP;
				if (stat.done)
					state_d = S_FIN;
			end
			S_LOOKUP: begin
				op = OP_LOOKUP;
				if (stat.done)
					state_d = S_LOOK_CHK;
			end
			S_LOOK_CHK: begin
				if (stat.hit) begin
					state_d = S_POS;
				end else begin
					code_d  = ST_UNKNOWN;
					state_d = S_FIN;
				end
			end
			S_POS: begin
				op = OP_POS;
				if (stat.done)
					state_d = S_POS_CHK;
			end
			S_POS_CHK: begin
				if (stat.left || stat.right) begin
					state_d = S_MERGE;
				end else if (stat.full) begin
					code_d  = ST_TABLE_FULL;
					state_d = S_FIN;
				end else begin
					state_d = S_SHUP;
				end
			end
			S_MERGE: begin
				op      = OP_MERGE;
				code_d  = ST_OK;
				state_d = (stat.left && stat.right) ? S_DROP : S_FIN;
			end
			S_SHUP: begin
				op = OP_SHUP;
				if (stat.done)
					state_d = S_INSERT;
			end
			S_INSERT: begin
				op      = OP_INSERT;
				code_d  = ST_OK;
				state_d = S_FIN;
			end
			S_FIN: begin
				if (res_load) begin
					op      = OP_RESULT;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign cmd.load  = in_valid && in_ready;
	assign cmd.start = start_q;
	assign cmd.op    = op;
	assign cmd.code  = code_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			code_q      <= ST_OK;
			init_q      <= 1'b1;
			start_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			code_q  <= code_d;
			// first cycle of every state restarts the datapath counters
			start_q <= (state_d != state_q);
			if (cfg_we)
				init_q <= 1'b1;
			else if (state_q == S_INIT)
				init_q <= 1'b0;
			if (res_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

endmodule

>>> rtl/bfa_dp.sv
// datapath of the best-fit allocator: free list memory, use table memory,
// scan counters and result registers; depends on bfa_pkg, driven by bfa_ctrl
module bfa_dp #(
	parameter int FREE_ENTRIES = bfa_pkg::FREE_ENTRIES_DEF,
	parameter int USED_ENTRIES = bfa_pkg::USED_ENTRIES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  bfa_pkg::bfa_cmd_t  cmd,
	output bfa_pkg::bfa_stat_t stat,
	input  logic               cfg_we,
	input  logic [32:0]        cfg_wdata,
	output logic [32:0]        pool_size,
	input  logic               func,
	input  logic [32:0]        request_size,
	input  logic [31:0]        block_offset,
	output logic [31:0]        granted_offset,
	output logic [32:0]        freed_size,
	output logic [2:0]         status
);
	import bfa_pkg::*;

	localparam int FIW = $clog2(FREE_ENTRIES);
	localparam int CW  = $clog2(FREE_ENTRIES + 1);
	localparam int UIW = $clog2(USED_ENTRIES);
	localparam int UCW = $clog2(USED_ENTRIES + 1);

	typedef struct packed {
		logic [32:0] s;
		logic [32:0] e;
	} fent_t;

	typedef struct packed {
		logic [31:0] off;
		logic [32:0] len;
	} uent_t;

	fent_t fmem [FREE_ENTRIES];
	uent_t umem [USED_ENTRIES];

	logic [32:0]             pool_q;
	logic [CW-1:0]           cnt_q;
	logic                    func_q;
	logic [32:0]             req_q;
	logic [31:0]             off_q;
	logic [CW-1:0]           fidx_q;
	logic [UCW-1:0]          uidx_q;
	logic                    frv_s1, urv_s1;
	logic [FIW-1:0]          fridx_s1;
	logic [UIW-1:0]          uridx_s1;
	fent_t                   fr_s1;
	uent_t                   ur_s1;
	logic [USED_ENTRIES-1:0] valid_q;
	logic [FIW-1:0]          best_idx_q;
	fent_t                   best_q;
	logic [32:0]             best_size_q;
	logic                    found_q, hit_q;
	logic [UIW-1:0]          slot_q;
	logic [32:0]             len_q, end_q;
	fent_t                   prev_q, cur_q;
	logic [CW-1:0]           pos_q;
	logic [FIW-1:0]          drop_q;
	logic [31:0]             granted_q;
	logic [32:0]             freed_q;
	logic [2:0]              status_q;

	logic           run;
	logic           fit_issue, pos_issue, drop_issue, shup_issue, f_issue, u_issue;
	logic [CW-1:0]  fidx_m1, pos_m1;
	logic [FIW-1:0] f_raddr;
	logic [32:0]    sz, new_start;
	logic           fit_take, pos_le, pos_stop, look_hit, slot_chk, slot_free, slot_last;
	logic           empty, left, right;
	logic           fwe;
	logic [FIW-1:0] fwa, fr_m1, fr_p1;
	fent_t          fwd;
	logic           done;

	assign run     = !cmd.start;
	assign fidx_m1 = fidx_q - 1'b1;
	assign pos_m1  = pos_q - 1'b1;
	assign fr_m1   = fridx_s1 - 1'b1;
	assign fr_p1   = fridx_s1 + 1'b1;

	assign fit_issue  = (cmd.op == OP_FIT) && run && (fidx_q < cnt_q);
	assign pos_issue  = (cmd.op == OP_POS) && run && (fidx_q < cnt_q);
	assign drop_issue = (cmd.op == OP_DROP) && run && (fidx_q < cnt_q);
	assign shup_issue = (cmd.op == OP_SHUP) && run && (fidx_q > pos_q);
	assign f_issue    = fit_issue || pos_issue || drop_issue || shup_issue;
	assign f_raddr    = shup_issue ? fidx_m1[FIW-1:0] : fidx_q[FIW-1:0];
	assign u_issue    = (cmd.op == OP_LOOKUP) && run && (uidx_q < UCW'(USED_ENTRIES));

	assign sz       = fr_s1.e - fr_s1.s;
	assign fit_take = (cmd.op == OP_FIT) && run && frv_s1 && (sz >= req_q)
	                  && (!found_q || sz < best_size_q);
	assign pos_le   = fr_s1.s <= {1'b0, off_q};
	assign pos_stop = (cmd.op == OP_POS) && run && frv_s1 && !pos_le;
	assign look_hit = (cmd.op == OP_LOOKUP) && run && urv_s1 && valid_q[uridx_s1]
	                  && (ur_s1.off == off_q);
	assign slot_chk  = (cmd.op == OP_SLOT) && run;
	assign slot_free = !valid_q[uidx_q[UIW-1:0]];
	assign slot_last = uidx_q == UCW'(USED_ENTRIES - 1);

	assign new_start = best_q.s + req_q;
	assign empty     = new_start == best_q.e;
	assign left      = (pos_q != '0) && (prev_q.e == {1'b0, off_q});
	assign right     = (pos_q < cnt_q) && (cur_q.s == end_q);

	always_comb begin
		unique case (cmd.op)
			OP_FIT, OP_DROP: done = run && (fidx_q >= cnt_q) && !frv_s1;
			OP_POS:          done = run && (pos_stop || ((fidx_q >= cnt_q) && !frv_s1));
			OP_SHUP:         done = run && (fidx_q <= pos_q) && !frv_s1;
			OP_LOOKUP:       done = run && (look_hit
			                        || ((uidx_q == UCW'(USED_ENTRIES)) && !urv_s1));
			OP_SLOT:         done = slot_chk && (slot_free || slot_last);
			default:         done = 1'b0;
		endcase
	end

	// single write port of the free list
	always_comb begin
		fwe = 1'b0;
		fwa = '0;
		fwd = fr_s1;
		unique case (cmd.op)
			OP_INIT: begin
				fwe = 1'b1;
				fwd = '{s: '0, e: pool_q};
			end
			OP_COMMIT: begin
				fwe = !empty;
				fwa = best_idx_q;
				fwd = '{s: new_start, e: best_q.e};
			end
			OP_MERGE: begin
				fwe = 1'b1;
				if (left) begin
					fwa = pos_m1[FIW-1:0];
					fwd = '{s: prev_q.s, e: (right ? cur_q.e : end_q)};
				end else begin
					fwa = pos_q[FIW-1:0];
					fwd = '{s: {1'b0, off_q}, e: cur_q.e};
				end
			end
			OP_DROP: begin
				fwe = frv_s1 && run;
				fwa = fr_m1;
			end
			OP_SHUP: begin
				fwe = frv_s1 && run;
				fwa = fr_p1;
			end
			OP_INSERT: begin
				fwe = 1'b1;
				fwa = pos_q[FIW-1:0];
				fwd = '{s: {1'b0, off_q}, e: end_q};
			end
			default: fwe = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (fwe)
			fmem[fwa] <= fwd;
		fr_s1 <= fmem[f_raddr];
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_COMMIT)
			umem[slot_q] <= '{off: best_q.s[31:0], len: req_q};
		ur_s1 <= umem[uidx_q[UIW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_q  <= POOL_RESET;
			cnt_q   <= '0;
			valid_q <= '0;
			fidx_q  <= '0;
			uidx_q  <= '0;
			frv_s1  <= 1'b0;
			urv_s1  <= 1'b0;
			found_q <= 1'b0;
			hit_q   <= 1'b0;
			func_q  <= 1'b0;
		end else begin
			if (cfg_we)
				pool_q <= (cfg_wdata > POOL_MAX) ? POOL_MAX : cfg_wdata;
			if (cmd.load)
				func_q <= func;
			frv_s1 <= f_issue;
			urv_s1 <= u_issue;

			if (cmd.start) begin
				unique case (cmd.op)
					OP_DROP: fidx_q <= CW'(drop_q) + 1'b1;
					OP_SHUP: fidx_q <= cnt_q;
					default: fidx_q <= '0;
				endcase
			end else if (fit_issue || pos_issue || drop_issue) begin
				fidx_q <= fidx_q + 1'b1;
			end else if (shup_issue) begin
				fidx_q <= fidx_m1;
			end

			if (cmd.start)
				uidx_q <= '0;
			else if (u_issue || (slot_chk && !done))
				uidx_q <= uidx_q + 1'b1;

			if (cmd.start && cmd.op == OP_FIT)
				found_q <= 1'b0;
			else if (fit_take)
				found_q <= 1'b1;

			if (cmd.start && (cmd.op == OP_LOOKUP || cmd.op == OP_SLOT))
				hit_q <= 1'b0;
			else if (look_hit || (slot_chk && slot_free))
				hit_q <= 1'b1;

			unique case (cmd.op)
				OP_INIT: begin
					valid_q <= '0;
					cnt_q   <= (pool_q != '0) ? CW'(1) : '0;
				end
				OP_COMMIT: valid_q[slot_q] <= 1'b1;
				OP_MERGE:  valid_q[slot_q] <= 1'b0;
				OP_INSERT: begin
					valid_q[slot_q] <= 1'b0;
					cnt_q           <= cnt_q + 1'b1;
				end
				OP_DROP: begin
					if (done)
						cnt_q <= cnt_q - 1'b1;
				end
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		fridx_s1 <= f_raddr;
		uridx_s1 <= uidx_q[UIW-1:0];
		if (cmd.load) begin
			req_q <= request_size;
			off_q <= block_offset;
		end
		if (fit_take) begin
			best_idx_q  <= fridx_s1;
			best_q      <= fr_s1;
			best_size_q <= sz;
		end
		if (look_hit) begin
			slot_q <= uridx_s1;
			len_q  <= ur_s1.len;
		end else if (slot_chk && slot_free) begin
			slot_q <= uidx_q[UIW-1:0];
		end
		if (cmd.op == OP_POS) begin
			if (cmd.start) begin
				pos_q <= cnt_q;
				end_q <= {1'b0, off_q} + len_q;
			end else if (pos_stop) begin
				pos_q <= CW'(fridx_s1);
				cur_q <= fr_s1;
			end else if (frv_s1) begin
				prev_q <= fr_s1;
			end
		end
		if (cmd.op == OP_COMMIT)
			drop_q <= best_idx_q;
		else if (cmd.op == OP_MERGE)
			drop_q <= pos_q[FIW-1:0];
		if (cmd.op == OP_RESULT) begin
			status_q <= cmd.code;
			if (func_q == FUNC_FREE)
				granted_q <= off_q;
			else
				granted_q <= (cmd.code == ST_OK) ? best_q.s[31:0] : '0;
			freed_q <= (func_q == FUNC_FREE && cmd.code == ST_OK) ? len_q : '0;
		end
	end

	assign stat.done     = done;
	assign stat.found    = found_q;
	assign stat.hit      = hit_q;
	assign stat.is_free  = func_q == FUNC_FREE;
	assign stat.req_zero = req_q == '0;
	assign stat.empty    = empty;
	assign stat.left     = left;
	assign stat.right    = right;
	assign stat.full     = cnt_q == CW'(FREE_ENTRIES);

	assign pool_size      = pool_q;
	assign granted_offset = granted_q;
	assign freed_size     = freed_q;
	assign status         = status_q;

endmodule

>>> rtl/best_fit_allocator_coalescing.sv
// best-fit allocator with coalescing free list; one item in flight
// allocate: best-fit scan of the free list, search for the lowest free use-table slot, commit,
// then a drop of the chosen block when it empties; free: use-table lookup of the offset
// (an unknown offset ends after a scan of the whole use table), free-list position search,
// then a merge with one or both neighbours (a drop when both merge) or an insert; result waits in an output register
// reset or a pool_size write holds in_ready low while the pool is rebuilt
module best_fit_allocator_coalescing #(
	parameter int FREE_ENTRIES = bfa_pkg::FREE_ENTRIES_DEF,
	parameter int USED_ENTRIES = bfa_pkg::USED_ENTRIES_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic                        func,
	input  logic [32:0]                 request_size,
	input  logic [31:0]                 block_offset,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [31:0]                 granted_offset,
	output logic [32:0]                 freed_size,
	output logic [2:0]                  status,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [bfa_pkg::PADDR_W-1:0] paddr,
	input  logic [bfa_pkg::PDATA_W-1:0] pwdata,
	output logic [bfa_pkg::PDATA_W-1:0] prdata,
	output logic                        pready
);
	import bfa_pkg::*;

	bfa_cmd_t    cmd;
	bfa_stat_t   stat;
	logic        cfg_we;
	logic        reg_hit;
	logic [32:0] pool;

	assign pready  = 1'b1;
	assign reg_hit = paddr[PADDR_W-1:3] == REG_POOL_SIZE;
	assign cfg_we  = psel && penable && pwrite && reg_hit;
	assign prdata  = reg_hit ? PDATA_W'(pool) : '0;

	bfa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.cmd      (cmd),
		.stat     (stat)
	);

	bfa_dp #(
		.FREE_ENTRIES(FREE_ENTRIES),
		.USED_ENTRIES(USED_ENTRIES)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.cfg_we        (cfg_we),
		.cfg_wdata     (pwdata[32:0]),
		.pool_size     (pool),
		.func          (func),
		.request_size  (request_size),
		.block_offset  (block_offset),
		.granted_offset(granted_offset),
		.freed_size    (freed_size),
		.status        (status)
	);

endmodule
